// File: design/fpdf_pkg.sv
// ----------------------------------------------------------------------------
// fpdf_pkg
// Shared constants and types for the fixed-point decimal formatter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int STEP_BITS      = 8;
  localparam int DIGITS         = 20;
  localparam int TEXT_CAP       = 22;

  localparam logic [6:0] CH_ZERO        = 7'h30;
  localparam logic [6:0] CH_DOT         = 7'h2E;
  localparam logic [6:0] MAX_LENGTH_RST = 7'd24;
  localparam logic       REG_MAX_LENGTH = 1'b0;

  typedef logic [DIGITS*4-1:0] bcd_t;

endpackage

// File: design/fpdf_dabble.sv
// ----------------------------------------------------------------------------
// fpdf_dabble
// One pipeline stage of the binary to BCD converter: STEP_BITS shift-add-3
// steps, registered, with valid/ready flow control.
// ----------------------------------------------------------------------------
module fpdf_dabble #(
  parameter int W = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [W-1:0]       in_bin,
  input  fpdf_pkg::bcd_t     in_bcd,
  input  logic [4:0]         in_dec,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [W-1:0]       out_bin,
  output fpdf_pkg::bcd_t     out_bcd,
  output logic [4:0]         out_dec
);
  import fpdf_pkg::*;

  logic         valid_r;
  logic [W-1:0] bin_r, bin_nxt;
  bcd_t         bcd_r, bcd_nxt;
  logic [4:0]   dec_r;

  always_comb begin
    bin_nxt = in_bin;
    bcd_nxt = in_bcd;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (bcd_nxt[d*4+:4] >= 4'd5) begin
          bcd_nxt[d*4+:4] = bcd_nxt[d*4+:4] + 4'd3;
        end
      end
      bcd_nxt = {bcd_nxt[DIGITS*4-2:0], bin_nxt[W-1]};
      bin_nxt = {bin_nxt[W-2:0], 1'b0};
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
      dec_r <= in_dec;
    end
  end

  assign out_valid = valid_r;
  assign out_bin   = bin_r;
  assign out_bcd   = bcd_r;
  assign out_dec   = dec_r;

endmodule

// File: design/fpdf_scan.sv
// ----------------------------------------------------------------------------
// fpdf_scan
// Finds the span of characters to print: most significant position, lowest
// printed position, presence of a fraction, and the character count.
// ----------------------------------------------------------------------------
module fpdf_scan (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpdf_pkg::bcd_t in_bcd,
  input  logic [4:0]     in_dec,
  output logic           out_valid,
  input  logic           out_ready,
  output fpdf_pkg::bcd_t out_bcd,
  output logic [4:0]     out_dec,
  output logic [4:0]     out_top,
  output logic [4:0]     out_low,
  output logic           out_frac,
  output logic [5:0]     out_count
);
  import fpdf_pkg::*;

  logic       valid_r;
  bcd_t       bcd_r;
  logic [4:0] dec_r, top_r, low_r, top_nxt, low_nxt;
  logic       frac_r, frac_nxt;
  logic [5:0] count_r, count_nxt;
  logic [4:0] msd, lz;
  logic       nz;

  always_comb begin
    msd = 5'd0;
    lz  = 5'd0;
    nz  = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (in_bcd[i*4+:4] != 4'd0) begin
        msd = 5'(i);
      end
    end
    for (int i = DIGITS - 1; i >= 0; i--) begin
      if (in_bcd[i*4+:4] != 4'd0) begin
        lz = 5'(i);
        nz = 1'b1;
      end
    end
    frac_nxt  = nz && (lz < in_dec);
    top_nxt   = (msd > in_dec) ? msd : in_dec;
    low_nxt   = frac_nxt ? lz : in_dec;
    count_nxt = {1'b0, top_nxt} - {1'b0, low_nxt} + 6'd1 + {5'd0, frac_nxt};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bcd_r   <= in_bcd;
      dec_r   <= in_dec;
      top_r   <= top_nxt;
      low_r   <= low_nxt;
      frac_r  <= frac_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_bcd   = bcd_r;
  assign out_dec   = dec_r;
  assign out_top   = top_r;
  assign out_low   = low_r;
  assign out_frac  = frac_r;
  assign out_count = count_r;

endmodule

// File: design/fpdf_emit.sv
// ----------------------------------------------------------------------------
// fpdf_emit
// Walks the digit span most significant first, inserts the dot, and drives
// the registered result word; gives the error word when the text is too long.
// ----------------------------------------------------------------------------
module fpdf_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [6:0]     max_length,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpdf_pkg::bcd_t in_bcd,
  input  logic [4:0]     in_dec,
  input  logic [4:0]     in_top,
  input  logic [4:0]     in_low,
  input  logic           in_frac,
  input  logic [5:0]     in_count,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_char_code,
  output logic           out_last,
  output logic           out_overflow_error,
  output logic [4:0]     out_text_length
);
  import fpdf_pkg::*;

  logic       busy_r, busy_nxt;
  bcd_t       bcd_r;
  logic [4:0] dec_r, low_r;
  logic [4:0] pos_r, pos_nxt;
  logic       frac_r, dot_r, dot_nxt, err_r;
  logic [5:0] count_r;
  logic       ovalid_r, ovalid_nxt;
  logic [6:0] char_r, char_nxt;
  logic       last_r, last_nxt, ovf_r, ovf_nxt;
  logic [4:0] len_r, len_nxt;
  logic       adv, take;
  logic [3:0] digit;

  assign adv      = !ovalid_r || out_ready;
  assign in_ready = !busy_r;
  assign take     = in_valid && !busy_r;

  always_comb begin
    digit = 4'd0;
    for (int i = 0; i < DIGITS; i++) begin
      if (pos_r == 5'(i)) begin
        digit = bcd_r[i*4+:4];
      end
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    pos_nxt    = pos_r;
    dot_nxt    = dot_r;
    ovalid_nxt = ovalid_r;
    char_nxt   = char_r;
    last_nxt   = last_r;
    ovf_nxt    = ovf_r;
    len_nxt    = len_r;
    if (adv) begin
      ovalid_nxt = busy_r;
      if (busy_r) begin
        if (err_r) begin
          char_nxt = 7'd0;
          last_nxt = 1'b1;
          ovf_nxt  = 1'b1;
          len_nxt  = 5'd0;
          busy_nxt = 1'b0;
        end else if (dot_r) begin
          char_nxt = CH_DOT;
          last_nxt = 1'b0;
          ovf_nxt  = 1'b0;
          len_nxt  = count_r[4:0];
          dot_nxt  = 1'b0;
          pos_nxt  = dec_r - 5'd1;
        end else begin
          char_nxt = CH_ZERO + {3'd0, digit};
          last_nxt = (pos_r == low_r);
          ovf_nxt  = 1'b0;
          len_nxt  = count_r[4:0];
          if (pos_r == low_r) begin
            busy_nxt = 1'b0;
          end else if (pos_r == dec_r && frac_r) begin
            dot_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r - 5'd1;
          end
        end
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      pos_nxt  = in_top;
      dot_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      dot_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      dot_r    <= dot_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    ovf_r  <= ovf_nxt;
    len_r  <= len_nxt;
    if (take) begin
      bcd_r   <= in_bcd;
      dec_r   <= in_dec;
      low_r   <= in_low;
      frac_r  <= in_frac;
      count_r <= in_count;
      err_r   <= ({1'b0, in_count} >= max_length) || (in_count > 6'(TEXT_CAP));
    end
  end

  assign out_valid          = ovalid_r;
  assign out_char_code      = char_r;
  assign out_last           = last_r;
  assign out_overflow_error = ovf_r;
  assign out_text_length    = len_r;

endmodule

// File: design/fixed_point_decimal_formatter.sv
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter
// Unsigned binary value to ASCII fixed-point decimal text, one char per word.
// ----------------------------------------------------------------------------
// An item passes ceil(VALUE_BITS/8) converter stages (eight shift-add-3 steps
// each) and one scan stage, then the character emitter, which holds one item
// at a time and gives one word per character of the text, or the single error
// word when the text is too long. The converter stages accept a new item every
// cycle while the next stage can take one, and buffer items while the emitter
// is busy. max_length at byte address 0 (reset 24).
module fixed_point_decimal_formatter #(
  parameter int VALUE_BITS = fpdf_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  input  logic [4:0]  in_decimals,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_char_code,
  output logic        out_last,
  output logic        out_overflow_error,
  output logic [4:0]  out_text_length
);
  import fpdf_pkg::*;

  localparam int STAGES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int W      = STAGES * STEP_BITS;

  logic [6:0] max_length_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LENGTH) ? {25'd0, max_length_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LENGTH) begin
      max_length_r <= pwdata[6:0];
    end
  end

  logic [W-1:0] bin_c [STAGES+1];
  bcd_t         bcd_c [STAGES+1];
  logic [4:0]   dec_c [STAGES+1];
  logic         vld_c [STAGES+1];
  logic         rdy_c [STAGES+1];

  assign bin_c[0] = W'(in_value[VALUE_BITS-1:0]);
  assign bcd_c[0] = '0;
  assign dec_c[0] = in_decimals;
  assign vld_c[0] = in_valid;
  assign in_ready = rdy_c[0];

  for (genvar g = 0; g < STAGES; g++) begin : g_conv
    fpdf_dabble #(.W(W)) u_dabble (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld_c[g]),
      .in_ready  (rdy_c[g]),
      .in_bin    (bin_c[g]),
      .in_bcd    (bcd_c[g]),
      .in_dec    (dec_c[g]),
      .out_valid (vld_c[g+1]),
      .out_ready (rdy_c[g+1]),
      .out_bin   (bin_c[g+1]),
      .out_bcd   (bcd_c[g+1]),
      .out_dec   (dec_c[g+1])
    );
  end

  logic       sc_valid, sc_ready, sc_frac;
  bcd_t       sc_bcd;
  logic [4:0] sc_dec, sc_top, sc_low;
  logic [5:0] sc_count;

  fpdf_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_c[STAGES]),
    .in_ready  (rdy_c[STAGES]),
    .in_bcd    (bcd_c[STAGES]),
    .in_dec    (dec_c[STAGES]),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_bcd   (sc_bcd),
    .out_dec   (sc_dec),
    .out_top   (sc_top),
    .out_low   (sc_low),
    .out_frac  (sc_frac),
    .out_count (sc_count)
  );

  fpdf_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .max_length         (max_length_r),
    .in_valid           (sc_valid),
    .in_ready           (sc_ready),
    .in_bcd             (sc_bcd),
    .in_dec             (sc_dec),
    .in_top             (sc_top),
    .in_low             (sc_low),
    .in_frac            (sc_frac),
    .in_count           (sc_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char_code      (out_char_code),
    .out_last           (out_last),
    .out_overflow_error (out_overflow_error),
    .out_text_length    (out_text_length)
  );

  a_err_word : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_error |->
      out_last && out_char_code == 7'd0 && out_text_length == 5'd0)
    else $error("error word malformed");

  a_len_fits : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow_error |->
      out_text_length != 5'd0 && {2'd0, out_text_length} < max_length_r)
    else $error("text length exceeds buffer limit");

  a_digit_or_dot : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow_error |->
      out_char_code == CH_DOT ||
      (out_char_code >= CH_ZERO && out_char_code <= CH_ZERO + 7'd9))
    else $error("bad character code");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the fixed-point decimal formatter. Drives value/decimals words
// through valid/ready, writes max_length over the APB port once the output has
// drained, predicts the character stream of each item and checks every output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fpdf_pkg::*;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
    logic       overflow_error;
    logic [4:0] text_length;
  } char_word_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_value;
  logic [4:0]  in_decimals;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  out_char_code;
  logic        out_last;
  logic        out_overflow_error;
  logic [4:0]  out_text_length;

  char_word_t  expected_chars[$];
  logic [6:0]  buf_limit;
  int          fail_count;
  int          word_count;
  int          item_count;
  int          error_words;
  int          cycle_count;
  int          idle_pct;
  int          hold_off;

  localparam int CYCLE_LIMIT = 400000;

  fixed_point_decimal_formatter u_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_value(in_value),
    .in_decimals(in_decimals),
    .out_valid(out_valid), .out_ready(out_ready), .out_char_code(out_char_code),
    .out_last(out_last), .out_overflow_error(out_overflow_error),
    .out_text_length(out_text_length)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic predict_text(input logic [63:0] value, input logic [4:0] decimals);
    logic [63:0] v;
    logic [6:0]  rev[40];
    int          n;
    int          pos;
    bit          shown;
    int          digit;
    char_word_t  w;
    v = value;
    n = 0;
    pos = 0;
    shown = 0;
    forever begin
      digit = int'(v % 64'd10);
      v = v / 64'd10;
      if (pos == decimals) begin
        if (shown && decimals != 0 && n < 40) begin
          rev[n] = CH_DOT;
          n++;
        end
        shown = 1;
      end
      if (digit != 0) shown = 1;
      if ((shown || decimals == 0) && n < 40) begin
        rev[n] = CH_ZERO + 7'(digit);
        n++;
      end
      if (v == 0 && decimals <= pos) break;
      pos++;
    end
    if (n >= buf_limit || n > TEXT_CAP) begin
      w = '{char_code: 7'd0, last: 1'b1, overflow_error: 1'b1, text_length: 5'd0};
      expected_chars.push_back(w);
    end else begin
      for (int k = 0; k < n; k++) begin
        w.char_code = rev[n - 1 - k];
        w.last = (k + 1 == n);
        w.overflow_error = 1'b0;
        w.text_length = 5'(n);
        expected_chars.push_back(w);
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH word %0d %s: got %0h want %0h", word_count, what, got, want);
    fail_count++;
  endtask

  task automatic send_item(input logic [63:0] value, input logic [4:0] decimals);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    predict_text(value, decimals);
    in_valid <= 1'b1;
    in_value <= value;
    in_decimals <= decimals;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(input logic [6:0] limit);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= 32'(limit);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    buf_limit = limit;
  endtask

  function automatic logic [63:0] rand_value;
    logic [63:0] v;
    int          width;
    v = {$urandom, $urandom};
    width = $urandom_range(64, 1);
    if (width < 64) v = v & ((64'd1 << width) - 1);
    if ($urandom_range(3) == 0) v = v - (v % 64'd1000);
    return v;
  endfunction

  task automatic test_directed;
    send_item(64'd0, 5'd0);
    send_item(64'd0, 5'd31);
    send_item(64'd7, 5'd0);
    send_item(64'd1234500, 5'd2);
    send_item(64'd1234500, 5'd3);
    send_item(64'd5, 5'd3);
    send_item(64'd100, 5'd2);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 5'd19);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 5'd20);
    send_item(64'd1, 5'd20);
    send_item(64'd1, 5'd21);
    send_item(64'd1, 5'd31);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 5'd10);
    send_item(64'h5555_5555_5555_5555, 5'd5);
    send_item(64'd10, 5'd1);
  endtask

  task automatic test_limits;
    write_limit(7'd0);
    send_item(64'd3, 5'd0);
    write_limit(7'd1);
    send_item(64'd3, 5'd0);
    write_limit(7'd2);
    send_item(64'd3, 5'd0);
    send_item(64'd35, 5'd0);
    write_limit(7'd4);
    send_item(64'd123, 5'd0);
    send_item(64'd1234, 5'd0);
    write_limit(7'd127);
    send_item(64'd1, 5'd21);
    write_limit(7'd64);
  endtask

  task automatic test_random;
    for (int i = 0; i < 220; i++) begin
      if (i == 80) begin
        idle_pct = 0;
      end else if (i == 140) begin
        idle_pct = 32;
        write_limit(7'($urandom_range(23, 5)));
      end else if (i == 180) begin
        drain();
        write_limit(7'd24);
      end
      send_item(rand_value(), 5'($urandom_range(99) < 90 ? $urandom_range(20) :
                                  $urandom_range(31)));
    end
  endtask

  task automatic test_backpressure;
    hold_off = 300;
    for (int i = 0; i < 20; i++) send_item(rand_value(), 5'($urandom_range(20)));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    char_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report("unexpected word", 32'(out_char_code), 32'd0);
      end else begin
        w = expected_chars.pop_front();
        if (out_char_code !== w.char_code) report("char_code", 32'(out_char_code),
                                                 32'(w.char_code));
        if (out_last !== w.last) report("last", 32'(out_last), 32'(w.last));
        if (out_overflow_error !== w.overflow_error)
          report("overflow_error", 32'(out_overflow_error), 32'(w.overflow_error));
        if (out_text_length !== w.text_length)
          report("text_length", 32'(out_text_length), 32'(w.text_length));
        if (w.overflow_error) error_words++;
      end
      word_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    in_valid = 1'b0;
    in_value = 64'd0;
    in_decimals = 5'd0;
    buf_limit = MAX_LENGTH_RST;
    fail_count = 0;
    word_count = 0;
    item_count = 0;
    error_words = 0;
    cycle_count = 0;
    idle_pct = 32;
    hold_off = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limits();
    test_backpressure();
    drain();
    test_random();
    drain();
    $display("Sent %0d items, checked %0d output words, %0d overflow errors,",
             item_count, word_count, error_words);
    $display("across buffer limits from 0 to 127 and with output back-pressure.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
